>>> hw/rtl/bba_pkg.sv
// shared types and constants for the buddy block allocator
package bba_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned EXP_W = 5;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_HEAP_BASE  = 2'd0,
    REG_HEAP_LIMIT = 2'd1,
    REG_FRESH_MIN  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP,
    S_FRESH,
    S_SPLIT,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [31:0] block_address;
    logic [4:0]  block_exponent;
  } req_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic [4:0]  granted_exponent;
    logic [1:0]  status;
    logic        half_dropped;
  } rsp_t;

endpackage

>>> hw/rtl/bba_ram.sv
// generic single-port synchronous ram with registered read
module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/buddy_block_allocator.sv
// buddy block allocator top level: free list memory, level counts, sequencer
//
// channel  | signals                         | transfer
// ---------+---------------------------------+---------------------------
// request  | start, busy, req                | start high while busy low
// result   | done, rsp                       | every cycle done is high
// config   | cfg_we, cfg_index, cfg_data     | every cycle cfg_we is high
//
// a free passes through scan and done; an allocate computes its exponent in scan, scans
// the levels, and on a pop reads the entry in pop before splitting one level per split
// step; a fresh block split down from MAX_EXP to MIN_EXP is the longest case; the
// sequence is bound by the one-access-per-cycle free list memory port.
// rst clears the level counts and loads the register defaults; list entries
// hold no reset value. the result is shown for one cycle and cannot be stalled.
module buddy_block_allocator #(
  parameter int unsigned MIN_EXP    = 5,
  parameter int unsigned MAX_EXP    = 20,
  parameter int unsigned LIST_DEPTH = 64,
  parameter int unsigned ADDR_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bba_pkg::req_t       req,
  output logic                done,
  output bba_pkg::rsp_t       rsp,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int unsigned LEVELS = MAX_EXP - MIN_EXP + 1;
  localparam int unsigned LW = $clog2(LEVELS);
  localparam int unsigned DW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MW = LW + DW;

  logic [ADDR_WIDTH-1:0] heap_limit, fresh_pointer, fresh_pointer_next;
  logic [4:0] fresh_min;
  logic [CW-1:0] counts [LEVELS];

  bba_pkg::fsm_t state, state_next;
  bba_pkg::req_t cur, cur_next;
  logic [5:0] e, e_next, lvl, lvl_next;
  logic [ADDR_WIDTH-1:0] block, block_next;
  logic [1:0] status, status_next;
  logic dropped, dropped_next;

  logic mem_we;
  logic [MW-1:0] mem_addr;
  logic [ADDR_WIDTH-1:0] mem_wdata, mem_rdata;

  logic cnt_inc, cnt_dec;
  logic [LW-1:0] cnt_lvl;

  bba_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(1 << MW)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_rdata)
  );

  // round-up exponent: ceil(log2(size)) clamped at MIN_EXP
  logic [5:0] req_exp;
  logic [32:0] sm1;
  always_comb begin
    sm1 = {1'b0, cur.request_size} - 33'd1;
    req_exp = 6'(MIN_EXP);
    for (int i = 0; i < 33; i++) begin
      if (sm1[i] && cur.request_size > 32'd1 && 6'(i + 1) > req_exp) begin
        req_exp = 6'(i + 1);
      end
    end
  end

  logic oversize;
  assign oversize = {1'b0, cur.request_size} > (33'd1 << MAX_EXP);

  logic [5:0] fresh_t;
  assign fresh_t = ({1'b0, fresh_min} > e) ? {1'b0, fresh_min} : e;

  logic [ADDR_WIDTH:0] fresh_bytes;
  assign fresh_bytes = (ADDR_WIDTH + 1)'(1) << fresh_t;

  logic fresh_fit;
  assign fresh_fit = (fresh_pointer <= heap_limit) &&
                     ({1'b0, heap_limit - fresh_pointer} >= fresh_bytes);

  logic [LW-1:0] lvl_idx;
  assign lvl_idx = LW'(lvl - 6'(MIN_EXP));
  logic [CW-1:0] lvl_cnt;
  assign lvl_cnt = counts[lvl_idx];

  logic free_ok;
  assign free_ok = ({1'b0, cur.block_exponent} >= 6'(MIN_EXP)) &&
                   ({1'b0, cur.block_exponent} <= 6'(MAX_EXP));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_IDLE;
      heap_limit <= ADDR_WIDTH'(32'hFFFF_FFFF);
      fresh_min <= 5'd12;
      fresh_pointer <= '0;
      for (int i = 0; i < LEVELS; i++) counts[i] <= '0;
    end else begin
      state <= state_next;
      // a heap base write reloads the bump pointer
      if (cfg_we && cfg_index == bba_pkg::REG_HEAP_BASE) begin
        fresh_pointer <= ADDR_WIDTH'(cfg_data);
      end else begin
        fresh_pointer <= fresh_pointer_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::REG_HEAP_BASE: ;
          bba_pkg::REG_HEAP_LIMIT: heap_limit <= ADDR_WIDTH'(cfg_data);
          bba_pkg::REG_FRESH_MIN: fresh_min <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cnt_inc) begin
        counts[cnt_lvl] <= counts[cnt_lvl] + CW'(1);
      end else if (cnt_dec) begin
        counts[cnt_lvl] <= counts[cnt_lvl] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    e <= e_next;
    lvl <= lvl_next;
    block <= block_next;
    status <= status_next;
    dropped <= dropped_next;
  end

  always_comb begin
    state_next = state;
    cur_next = cur;
    e_next = e;
    lvl_next = lvl;
    block_next = block;
    status_next = status;
    dropped_next = dropped;
    fresh_pointer_next = fresh_pointer;
    mem_we = 1'b0;
    mem_addr = '0;
    mem_wdata = block;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    cnt_lvl = lvl_idx;
    busy = (state != bba_pkg::S_IDLE);
    done = 1'b0;
    rsp = '0;
    unique case (state)
      bba_pkg::S_IDLE: begin
        if (start) begin
          cur_next = req;
          state_next = bba_pkg::S_SCAN;
          status_next = bba_pkg::ST_OK;
          dropped_next = 1'b0;
          block_next = '0;
          e_next = '0;
          lvl_next = 6'(MIN_EXP);
        end
      end
      bba_pkg::S_SCAN: begin
        if (cur.mode) begin
          e_next = {1'b0, cur.block_exponent};
          if (free_ok && counts[LW'(cur.block_exponent - 5'(MIN_EXP))] <
              CW'(LIST_DEPTH)) begin
            cnt_lvl = LW'(cur.block_exponent - 5'(MIN_EXP));
            cnt_inc = 1'b1;
            mem_we = 1'b1;
            mem_addr = {cnt_lvl, DW'(counts[cnt_lvl])};
            mem_wdata = ADDR_WIDTH'(cur.block_address);
          end else begin
            status_next = bba_pkg::ST_LIST_FULL;
          end
          state_next = bba_pkg::S_DONE;
        end else if (oversize) begin
          status_next = bba_pkg::ST_TOO_BIG;
          state_next = bba_pkg::S_DONE;
        end else if (e == '0) begin
          e_next = req_exp;
          lvl_next = req_exp;
        end else if (lvl > 6'(MAX_EXP)) begin
          state_next = bba_pkg::S_FRESH;
        end else if (lvl_cnt != '0) begin
          cnt_dec = 1'b1;
          mem_addr = {lvl_idx, DW'(lvl_cnt - CW'(1))};
          state_next = bba_pkg::S_POP;
        end else begin
          lvl_next = lvl + 6'd1;
        end
      end
      bba_pkg::S_POP: begin
        block_next = mem_rdata;
        state_next = bba_pkg::S_SPLIT;
      end
      bba_pkg::S_FRESH: begin
        if (fresh_t > 6'(MAX_EXP) || !fresh_fit) begin
          status_next = bba_pkg::ST_NO_MEM;
          state_next = bba_pkg::S_DONE;
        end else begin
          block_next = fresh_pointer;
          fresh_pointer_next = fresh_pointer + fresh_bytes[ADDR_WIDTH-1:0];
          lvl_next = fresh_t;
          state_next = bba_pkg::S_SPLIT;
        end
      end
      bba_pkg::S_SPLIT: begin
        if (lvl <= e) begin
          state_next = bba_pkg::S_DONE;
        end else begin
          cnt_lvl = LW'(lvl - 6'd1 - 6'(MIN_EXP));
          if (counts[cnt_lvl] < CW'(LIST_DEPTH)) begin
            cnt_inc = 1'b1;
            mem_we = 1'b1;
            mem_addr = {cnt_lvl, DW'(counts[cnt_lvl])};
            mem_wdata = block + (ADDR_WIDTH'(1) << (lvl - 6'd1));
          end else begin
            dropped_next = 1'b1;
          end
          lvl_next = lvl - 6'd1;
        end
      end
      bba_pkg::S_DONE: begin
        done = 1'b1;
        state_next = bba_pkg::S_IDLE;
        rsp.status = status;
        rsp.granted_exponent = (status == bba_pkg::ST_TOO_BIG) ? 5'd0 : e[4:0];
        rsp.granted_address = (status == bba_pkg::ST_OK && !cur.mode) ?
                              32'(block) : 32'd0;
        rsp.half_dropped = (status == bba_pkg::ST_OK && !cur.mode) ? dropped : 1'b0;
      end
      default: state_next = bba_pkg::S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("done not followed by idle");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted start did not raise busy");
  a_drop_ok: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.half_dropped) |-> rsp.status == bba_pkg::ST_OK)
    else $error("half dropped on failed request");
`endif

endmodule
